// File: rtl/ipv6hc_pkg.sv
`default_nettype none

package ipv6hc_pkg;

  // Widths of the counted length and of the captured header fields.
  localparam int unsigned LenW  = 11;
  localparam int unsigned ByteW = 8;

  typedef logic [LenW-1:0]  len_t;
  typedef logic [ByteW-1:0] byte_t;

  // Header layout and protocol constants.
  localparam len_t  MinLen       = len_t'(40);
  localparam len_t  MaxClamp     = len_t'(2046);
  localparam len_t  MaxReset     = len_t'(1280);
  localparam len_t  UdpMinPktLen = len_t'(48);
  localparam len_t  IdxVersion   = len_t'(0);
  localparam len_t  IdxPayHi     = len_t'(4);
  localparam len_t  IdxPayLo     = len_t'(5);
  localparam len_t  IdxNextHdr   = len_t'(6);
  localparam len_t  IdxUdpHi     = len_t'(44);
  localparam len_t  IdxUdpLo     = len_t'(45);
  localparam logic [3:0]  VersionSix = 4'd6;
  localparam byte_t       ProtoUdp   = 8'd17;
  localparam byte_t       ProtoIcmp6 = 8'd58;
  localparam logic [15:0] UdpHdrLen  = 16'd8;
  localparam logic [15:0] IcmpMinLen = 16'd4;

  // Result codes, highest priority check first after OK.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_TOO_SHORT    = 3'd1,
    ST_TOO_LONG     = 3'd2,
    ST_BAD_VERSION  = 3'd3,
    ST_LEN_MISMATCH = 3'd4,
    ST_UDP_SHORT    = 3'd5,
    ST_UDP_BAD_LEN  = 3'd6,
    ST_ICMP_SHORT   = 3'd7
  } status_e;

  // Captured state of the packet in progress.
  typedef struct packed {
    len_t        count;
    logic [3:0]  version;
    logic [15:0] pay_len;
    byte_t       next_hdr;
    logic [15:0] udp_len;
  } pkt_fields_t;

endpackage

`default_nettype wire

// File: rtl/ipv6_packet_header_checker_top.sv
// Channel   Direction  tdata (low bit up)                      tuser  tlast
// s_axis    in         data_byte[7:0]                          -      last_byte
// m_axis    out        status[2:0], packet_length[13:3], 0s    -      -
// cfg       in         max_packet_length[10:0] (write only)    -      -
//
// One byte per cycle is accepted; only a last byte can stall, and only while
// a finished status is still unclaimed on m_axis. The counter and field
// captures update from the registered byte; a status word is valid once the
// last byte passes the input and result registers. Reset (rst_ni, async, low)
// clears the counter, captures, both valid flags, and sets the maximum to 1280.
`default_nettype none

module ipv6_packet_header_checker_top (
  input  wire         clk_i,
  input  wire         rst_ni,
  // Configuration: maximum packet length, clamped to 40..2046 on write.
  input  wire         cfg_we_i,
  input  wire  [10:0] cfg_wdata_i,
  // Input stream: tdata = data_byte[7:0], tlast = last_byte.
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,
  input  wire         s_axis_tlast_i,
  // Output stream: tdata = status[2:0], packet_length[13:3], zero pad [15:14].
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o
);
  import ipv6hc_pkg::*;

  len_t        max_q;
  logic        in_valid_q;
  byte_t       in_byte_q;
  logic        in_last_q;
  pkt_fields_t pkt_q, pkt_d;
  logic        out_valid_q;
  status_e     out_status_q;
  len_t        out_len_q;
  logic        advance;
  logic        counting;
  status_e     status;

  // Stored maximum is already clamped; the count stops at max_q plus one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxReset;
    end else if (cfg_we_i) begin
      if (cfg_wdata_i < MinLen) begin
        max_q <= MinLen;
      end else if (cfg_wdata_i > MaxClamp) begin
        max_q <= MaxClamp;
      end else begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // A non-last word always moves on; a last word needs a free output slot.
  assign advance         = in_valid_q && (!in_last_q || !out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
    end
  end

  // Counter update and header field capture for the registered word.
  assign counting = (pkt_q.count <= max_q);

  always_comb begin
    pkt_d = pkt_q;
    if (counting) begin
      pkt_d.count = pkt_q.count + len_t'(1);
      if (pkt_q.count == IdxVersion) begin
        pkt_d.version = in_byte_q[7:4];
      end else if (pkt_q.count == IdxPayHi) begin
        pkt_d.pay_len[15:8] = in_byte_q;
      end else if (pkt_q.count == IdxPayLo) begin
        pkt_d.pay_len[7:0] = in_byte_q;
      end else if (pkt_q.count == IdxNextHdr) begin
        pkt_d.next_hdr = in_byte_q;
      end else if (pkt_q.count == IdxUdpHi) begin
        pkt_d.udp_len[15:8] = in_byte_q;
      end else if (pkt_q.count == IdxUdpLo) begin
        pkt_d.udp_len[7:0] = in_byte_q;
      end
    end
  end

  ipv6hc_judge u_judge (
    .fields_i  (pkt_d),
    .max_len_i (max_q),
    .status_o  (status)
  );

  // Packet state returns to zero after each last word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pkt_q <= '0;
    end else if (advance) begin
      if (in_last_q) begin
        pkt_q <= '0;
      end else begin
        pkt_q <= pkt_d;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      out_status_q <= status;
      out_len_q    <= pkt_d.count;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_len_q, out_status_q};

`ifndef SYNTHESIS
  // The counter is back at zero after a packet ends.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_last_q) |=> (pkt_q.count == '0))
    else $error("packet state not cleared after last word");

  // An accepted packet lies within the length limits.
  a_ok_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == ST_OK)) |->
      ((out_len_q >= MinLen) && (out_len_q <= max_q)))
    else $error("OK status with out-of-range length");

  // A too-short status only goes with a short count.
  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == ST_TOO_SHORT)) |-> (out_len_q < MinLen))
    else $error("too-short status with long count");
`endif

endmodule

`default_nettype wire

// File: rtl/ipv6hc_judge.sv
`default_nettype none

module ipv6hc_judge (
  input  ipv6hc_pkg::pkt_fields_t fields_i,
  input  ipv6hc_pkg::len_t        max_len_i,
  output ipv6hc_pkg::status_e     status_o
);
  import ipv6hc_pkg::*;

  logic [16:0] want_len;
  logic        is_udp;
  logic        is_icmp;
  logic        udp_len_bad;

  assign want_len     = 17'(MinLen) + {1'b0, fields_i.pay_len};
  assign is_udp       = (fields_i.next_hdr == ProtoUdp);
  assign is_icmp      = (fields_i.next_hdr == ProtoIcmp6);
  // The UDP length field is only present once the UDP header has arrived.
  assign udp_len_bad  = (fields_i.count >= UdpMinPktLen) &&
                        ((fields_i.udp_len < UdpHdrLen) ||
                         (fields_i.udp_len > fields_i.pay_len));

  // Priority chain of the checks.
  always_comb begin
    if (fields_i.count < MinLen) begin
      status_o = ST_TOO_SHORT;
    end else if (fields_i.count > max_len_i) begin
      status_o = ST_TOO_LONG;
    end else if (fields_i.version != VersionSix) begin
      status_o = ST_BAD_VERSION;
    end else if (want_len != {6'd0, fields_i.count}) begin
      status_o = ST_LEN_MISMATCH;
    end else if (is_udp && (fields_i.pay_len < UdpHdrLen)) begin
      status_o = ST_UDP_SHORT;
    end else if (is_udp && udp_len_bad) begin
      status_o = ST_UDP_BAD_LEN;
    end else if (is_icmp && (fields_i.pay_len < IcmpMinLen)) begin
      status_o = ST_ICMP_SHORT;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ipv6hc_pkg::*;

  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned HoldCycles = 300;

  // Predicts the status word of each packet from the bytes the block accepts.
  class ipv6_len_scoreboard;
    typedef struct {
      status_e st;
      len_t    len;
    } status_word_t;

    len_t         max_reg;
    len_t         count;
    logic [3:0]   version;
    logic [15:0]  pay_len;
    byte_t        next_hdr;
    logic [15:0]  udp_len;
    status_word_t expected_words[$];
    int unsigned  errors;
    int unsigned  bytes_seen;
    int unsigned  words_seen;
    bit [7:0]     seen_codes;

    function new();
      max_reg    = MaxReset;
      errors     = 0;
      bytes_seen = 0;
      words_seen = 0;
      seen_codes = '0;
      clear_packet();
    endfunction

    function void clear_packet();
      count    = '0;
      version  = '0;
      pay_len  = '0;
      next_hdr = '0;
      udp_len  = '0;
    endfunction

    function void write_max(logic [10:0] v);
      max_reg = v;
    endfunction

    // The register is clamped to 40..2046 before use.
    function len_t eff_max();
      len_t m;
      m = max_reg;
      if (m < MinLen) m = MinLen;
      if (m > MaxClamp) m = MaxClamp;
      return m;
    endfunction

    function status_e judge(len_t maxlen);
      if (count < MinLen) return ST_TOO_SHORT;
      if (count > maxlen) return ST_TOO_LONG;
      if (version != VersionSix) return ST_BAD_VERSION;
      if (32'(MinLen) + 32'(pay_len) != 32'(count)) return ST_LEN_MISMATCH;
      if (next_hdr == ProtoUdp) begin
        if (pay_len < UdpHdrLen) return ST_UDP_SHORT;
        if (count >= UdpMinPktLen && (udp_len < UdpHdrLen || udp_len > pay_len))
          return ST_UDP_BAD_LEN;
      end else if (next_hdr == ProtoIcmp6 && pay_len < IcmpMinLen) begin
        return ST_ICMP_SHORT;
      end
      return ST_OK;
    endfunction

    function void note_byte(byte_t b, logic last);
      len_t         maxlen;
      status_word_t w;
      maxlen = eff_max();
      bytes_seen++;
      // Bytes past the saturation point are neither counted nor captured.
      if (count <= maxlen) begin
        case (count)
          IdxVersion: version         = b[7:4];
          IdxPayHi:   pay_len[15:8]   = b;
          IdxPayLo:   pay_len[7:0]    = b;
          IdxNextHdr: next_hdr        = b;
          IdxUdpHi:   udp_len[15:8]   = b;
          IdxUdpLo:   udp_len[7:0]    = b;
          default: ;
        endcase
        count = count + 1'b1;
      end
      if (last) begin
        w.st  = judge(maxlen);
        w.len = count;
        expected_words.push_back(w);
        clear_packet();
      end
    endfunction

    function void flag(string what, int unsigned exp_v, int unsigned act_v);
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch in %s: expected %0d, got %0d", $realtime, what, exp_v, act_v);
    endfunction

    function void check_word(logic [15:0] w);
      status_word_t e;
      words_seen++;
      if (expected_words.size() == 0) begin
        flag("status word with none pending", 0, w);
        return;
      end
      e = expected_words.pop_front();
      seen_codes[e.st] = 1'b1;
      if (w[2:0] !== e.st) flag("status", e.st, w[2:0]);
      if (w[13:3] !== e.len) flag("packet length", e.len, w[13:3]);
      if (w[15:14] !== 2'b00) flag("pad bits", 0, w[15:14]);
    endfunction

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  wire         s_tready;
  wire         m_tvalid;
  logic        m_tready = 1'b0;
  wire  [15:0] m_tdata;

  ipv6_len_scoreboard sb = new();
  byte_t       pkt[$];
  int unsigned tx_idle = 31;
  int unsigned rx_idle = 46;
  logic        hold_req = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;
  int unsigned packets_sent = 0;

  ipv6_packet_header_checker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  always @(posedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_idle);
    end
  end

  // Watch both streams and feed the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) sb.check_word(m_tdata);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  task automatic send_byte(byte_t b, logic last);
    if ($urandom_range(0, 99) < tx_idle) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt.size(); i++) send_byte(pkt[i], i == pkt.size() - 1);
    packets_sent++;
  endtask

  // Drain all pending status words, then let the pipeline settle.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic set_max(logic [10:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.write_max(v);
  endtask

  // Random filler with the header fields placed where the block looks for them.
  task automatic build_packet(int n, logic [3:0] ver, logic [15:0] pay, byte_t nh,
                              logic [15:0] udp);
    pkt.delete();
    for (int i = 0; i < n; i++) pkt.push_back(byte_t'($urandom_range(0, 255)));
    if (n > 0) pkt[0][7:4] = ver;
    if (n > 4) pkt[4] = pay[15:8];
    if (n > 5) pkt[5] = pay[7:0];
    if (n > 6) pkt[6] = nh;
    if (n > 44) pkt[44] = udp[15:8];
    if (n > 45) pkt[45] = udp[7:0];
  endtask

  task automatic flat_packet(int n, byte_t v);
    pkt.delete();
    for (int i = 0; i < n; i++) pkt.push_back(v);
  endtask

  // Mostly well-formed headers with random content, some noise and bad lengths.
  task automatic random_packet(len_t maxeff);
    int          n;
    int unsigned r;
    bit          well;
    logic [15:0] pay;
    logic [15:0] udp;
    byte_t       nh;
    r = $urandom_range(0, 99);
    if (r < 12) n = $urandom_range(1, 39);
    else if (r < 24 && maxeff <= 200) n = $urandom_range(maxeff + 1, maxeff + 12);
    else n = $urandom_range(40, (maxeff < 64) ? maxeff : 64);
    well = ($urandom_range(0, 99) < 80);
    if (n >= 40 && $urandom_range(0, 99) < 90) pay = 16'(n - 40);
    else pay = 16'($urandom_range(0, 65535));
    r = $urandom_range(0, 99);
    nh = (r < 40) ? ProtoUdp : (r < 70) ? ProtoIcmp6 : byte_t'($urandom_range(0, 255));
    if ($urandom_range(0, 1)) udp = 16'($urandom_range(0, int'(pay) + 2));
    else udp = 16'($urandom_range(0, 65535));
    build_packet(n, well ? VersionSix : 4'($urandom_range(0, 15)), pay, nh, udp);
  endtask

  task automatic run_random(int min_bytes, int min_pkts, bit pause_mid);
    int nb;
    int np;
    nb = 0;
    np = 0;
    while (nb < min_bytes || np < min_pkts) begin
      random_packet(sb.eff_max());
      send_packet();
      nb += pkt.size();
      np++;
      // Once, hold the sender back until every status word is home.
      if (pause_mid && np == 2) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() > 0) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed packets at the reset maximum of 1280.
    build_packet(40, VersionSix, 16'd0, 8'd0, 16'd0);       send_packet();
    build_packet(1, VersionSix, 16'd0, 8'd0, 16'd0);        send_packet();
    build_packet(39, VersionSix, 16'd0, ProtoUdp, 16'd0);   send_packet();
    flat_packet(40, 8'hFF);                                 send_packet();
    build_packet(41, VersionSix, 16'd9, 8'd0, 16'd0);       send_packet();
    build_packet(44, VersionSix, 16'd4, ProtoUdp, 16'd0);   send_packet();
    build_packet(48, VersionSix, 16'd8, ProtoUdp, 16'd7);   send_packet();
    build_packet(48, VersionSix, 16'd8, ProtoUdp, 16'd9);   send_packet();
    build_packet(48, VersionSix, 16'd8, ProtoUdp, 16'd8);   send_packet();
    build_packet(43, VersionSix, 16'd3, ProtoIcmp6, 16'd0); send_packet();
    build_packet(44, VersionSix, 16'd4, ProtoIcmp6, 16'd0); send_packet();

    // Smallest maximum: too-long packets and saturation of the count.
    set_max(11'd40);
    build_packet(41, VersionSix, 16'd1, 8'd0, 16'd0);       send_packet();
    build_packet(60, VersionSix, 16'd20, ProtoUdp, 16'd20); send_packet();
    build_packet(40, VersionSix, 16'd0, ProtoUdp, 16'd0);   send_packet();

    // A register below 40 is clamped up.
    set_max(11'd0);
    build_packet(40, VersionSix, 16'd0, ProtoIcmp6, 16'd0); send_packet();

    // All ones is clamped down to 2046.
    set_max(11'h7FF);
    build_packet(41, VersionSix, 16'd1, 8'd0, 16'd0);       send_packet();

    // Random traffic; the first phase opens with a long receiver hold-off.
    set_max(11'd100);
    hold_req <= 1'b1;
    run_random(100, 3, 1'b0);

    wait_idle();
    tx_idle = 46;
    rx_idle <= 31;
    set_max(11'd1280);
    run_random(100, 3, 1'b1);

    wait_idle();
    tx_idle = 0;
    rx_idle <= 0;
    set_max(11'd55);
    run_random(100, 3, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes in %0d packets under seven length limits; %0d status words checked.",
             sb.bytes_seen, packets_sent, sb.words_seen);
    $display("%0d of 8 status codes were exercised, %0d errors.",
             $countones(sb.seen_codes), sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: ipv6_packet_header_checker_top.f
rtl/ipv6hc_pkg.sv
rtl/ipv6hc_judge.sv
rtl/ipv6_packet_header_checker_top.sv
bench/tb_top.sv
